[hw/rtl/rlns_pkg.sv]
// Package for the radius limited nearest selector.
// Holds default sizes, request codes, word types and the control state type.
// No dependencies.
package rlns_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int MAX_SELECT_DEF  = 8;

  localparam int SLOT_IDX_W = 6;
  localparam int COORD_W    = 16;
  localparam int RADIUS_W   = 16;
  localparam int DIST_W     = 34;
  localparam int SQ_W       = 32;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic [SLOT_IDX_W-1:0]        slot_index;
    logic                         slot_valid;
    logic                         slot_enabled;
    logic signed [COORD_W-1:0]    pos_x;
    logic signed [COORD_W-1:0]    pos_y;
    logic signed [COORD_W-1:0]    pos_z;
    logic [RADIUS_W-1:0]          radius;
  } req_word_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] hit_slot;
    logic [DIST_W-1:0]     hit_dist_sq;
    logic                  hit_found;
    logic                  last;
  } rsp_word_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } sel_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } rlns_state_e;

endpackage

[hw/rtl/rlns_req_if.sv]
// Request channel of the radius limited nearest selector.
// Carries one request word with valid and ready; depends on rlns_pkg.
interface rlns_req_if;
  import rlns_pkg::*;

  logic      valid;
  logic      ready;
  req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rlns_rsp_if.sv]
// Response channel of the radius limited nearest selector.
// Carries one response word with valid and ready; depends on rlns_pkg.
interface rlns_rsp_if;
  import rlns_pkg::*;

  logic      valid;
  logic      ready;
  rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rlns_ram.sv]
// Generic simple dual port RAM with one write port and a registered read.
// No dependencies.
module rlns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rlns_topk.sv]
// Sorted list of the nearest hits found so far, nearest at the head.
// Inserts one candidate per cycle and shifts out from the head; uses rlns_pkg.
module rlns_topk #(
  parameter int MAX_SELECT = rlns_pkg::MAX_SELECT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rlns_pkg::sel_ctrl_t                ctrl_i,
  input  logic [rlns_pkg::DIST_W-1:0]        cand_dist_i,
  input  logic [rlns_pkg::SLOT_IDX_W-1:0]    cand_slot_i,
  output logic [rlns_pkg::DIST_W-1:0]        head_dist_o,
  output logic [rlns_pkg::SLOT_IDX_W-1:0]    head_slot_o,
  output logic [$clog2(MAX_SELECT+1)-1:0]    count_o
);
  import rlns_pkg::*;

  localparam int CNT_W = $clog2(MAX_SELECT + 1);

  logic [DIST_W-1:0]     dist_q [MAX_SELECT];
  logic [DIST_W-1:0]     dist_d [MAX_SELECT];
  logic [SLOT_IDX_W-1:0] slot_q [MAX_SELECT];
  logic [SLOT_IDX_W-1:0] slot_d [MAX_SELECT];
  logic [MAX_SELECT-1:0] ins;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  for (genvar k = 0; k < MAX_SELECT; k++) begin : g_entry
    logic          first_ins;
    logic          shift_in;
    logic [DIST_W-1:0]     up_dist;
    logic [SLOT_IDX_W-1:0] up_slot;

    assign ins[k] = (CNT_W'(k) >= cnt_q) || (cand_dist_i < dist_q[k]);

    if (k == 0) begin : g_first
      assign first_ins = ins[k];
      assign shift_in  = 1'b0;
      assign up_dist   = dist_q[k];
      assign up_slot   = slot_q[k];
    end else begin : g_rest
      assign first_ins = ins[k] && !ins[k-1];
      assign shift_in  = ins[k] && ins[k-1];
      assign up_dist   = dist_q[k-1];
      assign up_slot   = slot_q[k-1];
    end

    always_comb begin
      dist_d[k] = dist_q[k];
      slot_d[k] = slot_q[k];
      if (ctrl_i.insert) begin
        if (first_ins) begin
          dist_d[k] = cand_dist_i;
          slot_d[k] = cand_slot_i;
        end else if (shift_in) begin
          dist_d[k] = up_dist;
          slot_d[k] = up_slot;
        end
      end else if (ctrl_i.pop) begin
        if (k < MAX_SELECT - 1) begin
          dist_d[k] = dist_q[(k + 1) % MAX_SELECT];
          slot_d[k] = slot_q[(k + 1) % MAX_SELECT];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dist_q[k] <= dist_d[k];
      slot_q[k] <= slot_d[k];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.insert) begin
      if (cnt_q < CNT_W'(MAX_SELECT)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (ctrl_i.pop) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_dist_o = dist_q[0];
  assign head_slot_o = slot_q[0];
  assign count_o     = cnt_q;

endmodule

[hw/rtl/radius_limited_nearest_selector.sv]
// Top level of the radius limited nearest selector.
// Depends on rlns_pkg, rlns_req_if, rlns_rsp_if, rlns_ram and rlns_topk.
//
// A write word stores a point in one slot and marks that slot active when
// both its valid and enable marks are set; it gives no response. A query
// word scans the slots one per cycle through the single read port of the
// coordinate RAM and drains the distance pipeline before its first response
// word; it then gives one word per cycle that the sink takes: up to
// MAX_SELECT hits, nearest first, ties to the lower slot, or one word with
// hit_found low when nothing lies within the radius. Only slots 0 to
// min(TABLE_DEPTH, 64) - 1 can be addressed. New requests are taken only
// after the final response word.
module radius_limited_nearest_selector #(
  parameter int TABLE_DEPTH = rlns_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_SELECT  = rlns_pkg::MAX_SELECT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlns_req_if.sink   req_i,
  rlns_rsp_if.source rsp_o
);
  import rlns_pkg::*;

  localparam int SLOTS  = (TABLE_DEPTH < (1 << SLOT_IDX_W)) ? TABLE_DEPTH
                                                           : (1 << SLOT_IDX_W);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(MAX_SELECT + 1);
  localparam int RAM_W  = 3 * COORD_W;

  rlns_state_e state_q, state_d;

  logic                 req_acc, rsp_acc, wr_en, in_range;
  logic [SLOTS-1:0]     active_q;
  logic [SLOT_W-1:0]    addr_q, addr_d;
  logic [RAM_W-1:0]     rdata;

  logic signed [COORD_W-1:0] tx_q, ty_q, tz_q;
  logic [SQ_W-1:0]           r2_q;

  logic                  v1_q, v2_q, v3_q;
  logic [SLOT_W-1:0]     slot1_q, slot2_q, slot3_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q, sqz_q;
  logic [DIST_W-1:0]     d3_q, d2_sum;

  logic signed [COORD_W:0]     dx, dy, dz;
  logic signed [2*COORD_W+1:0] px, py, pz;

  sel_ctrl_t             sel_ctrl;
  logic [DIST_W-1:0]     head_dist;
  logic [SLOT_IDX_W-1:0] head_slot;
  logic [CNT_W-1:0]      count;

  assign req_acc  = req_i.valid && req_i.ready;
  assign rsp_acc  = rsp_o.valid && rsp_o.ready;
  assign in_range = {1'b0, req_i.data.slot_index} < (SLOT_IDX_W + 1)'(SLOTS);
  assign wr_en    = req_acc && (req_i.data.req_type == REQ_WRITE) && in_range;

  rlns_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (req_i.data.slot_index[SLOT_W-1:0]),
    .wdata_i ({req_i.data.pos_x, req_i.data.pos_y, req_i.data.pos_z}),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (wr_en) begin
      active_q[req_i.data.slot_index[SLOT_W-1:0]] <=
        req_i.data.slot_valid && req_i.data.slot_enabled;
    end
  end

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    req_i.ready  = 1'b0;
    rsp_o.valid  = 1'b0;
    sel_ctrl     = '0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        addr_d      = '0;
        if (req_acc && (req_i.data.req_type == REQ_QUERY)) begin
          sel_ctrl.clear = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rsp_o.valid = 1'b1;
        if (rsp_acc) begin
          sel_ctrl.pop = 1'b1;
          if (count <= CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    sel_ctrl.insert = v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      v1_q    <= (state_q == ST_SCAN) && active_q[addr_q];
      v2_q    <= v1_q;
      v3_q    <= v2_q && (d2_sum <= DIST_W'(r2_q));
    end
  end

  always_comb begin
    dx = $signed({rdata[3*COORD_W-1], rdata[3*COORD_W-1:2*COORD_W]})
       - $signed({tx_q[COORD_W-1], tx_q});
    dy = $signed({rdata[2*COORD_W-1], rdata[2*COORD_W-1:COORD_W]})
       - $signed({ty_q[COORD_W-1], ty_q});
    dz = $signed({rdata[COORD_W-1], rdata[COORD_W-1:0]})
       - $signed({tz_q[COORD_W-1], tz_q});
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
    d2_sum = DIST_W'(sqx_q) + DIST_W'(sqy_q) + DIST_W'(sqz_q);
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      tx_q <= req_i.data.pos_x;
      ty_q <= req_i.data.pos_y;
      tz_q <= req_i.data.pos_z;
      r2_q <= req_i.data.radius * req_i.data.radius;
    end
    slot1_q <= addr_q;
    slot2_q <= slot1_q;
    slot3_q <= slot2_q;
    sqx_q   <= px[SQ_W-1:0];
    sqy_q   <= py[SQ_W-1:0];
    sqz_q   <= pz[SQ_W-1:0];
    d3_q    <= d2_sum;
  end

  rlns_topk #(
    .MAX_SELECT (MAX_SELECT)
  ) u_topk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sel_ctrl),
    .cand_dist_i (d3_q),
    .cand_slot_i (SLOT_IDX_W'(slot3_q)),
    .head_dist_o (head_dist),
    .head_slot_o (head_slot),
    .count_o     (count)
  );

  always_comb begin
    rsp_o.data.hit_found   = (count != '0);
    rsp_o.data.hit_slot    = (count != '0) ? head_slot : '0;
    rsp_o.data.hit_dist_sq = (count != '0) ? head_dist : '0;
    rsp_o.data.last        = (count <= CNT_W'(1));
  end

endmodule
